[src/qsh_pkg.sv]
// shared types and constants for the split-half qpsk mapper
// no dependencies

package qsh_pkg;

  localparam int MAX_HALF_BYTES = 256;
  localparam int ADDR_W         = $clog2(MAX_HALF_BYTES);
  localparam int LEN_W          = 9;
  localparam int SAMPLE_W       = 16;
  localparam int BITS_PER_BYTE  = 8;
  localparam int BIT_CNT_W      = $clog2(BITS_PER_BYTE);

  localparam logic [LEN_W-1:0] HALF_BYTES_RESET = LEN_W'(192);
  localparam logic [LEN_W-1:0] LEN_MIN          = LEN_W'(1);
  localparam logic [LEN_W-1:0] LEN_MAX          = LEN_W'(MAX_HALF_BYTES);

  localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(BITS_PER_BYTE - 1);

  // 1/sqrt2 in q0.32, rounded to nearest at the sample width
  localparam longint unsigned INV_SQRT2_Q32 = 64'd3037000500;
  localparam logic signed [SAMPLE_W-1:0] AMP_POS =
    SAMPLE_W'((INV_SQRT2_Q32 + (64'd1 << (32 - SAMPLE_W))) >> (33 - SAMPLE_W));
  localparam logic signed [SAMPLE_W-1:0] AMP_NEG = -AMP_POS;

  typedef logic [7:0]                 byte_t;
  typedef logic [ADDR_W-1:0]          addr_t;
  typedef logic [LEN_W-1:0]           len_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;

  function automatic sample_t map_bit(input logic b);
    return b ? AMP_NEG : AMP_POS;
  endfunction

endpackage

[src/qsh_if.sv]
// channel interfaces for the split-half qpsk mapper: byte input, symbol output, config
// depends on qsh_pkg

interface qsh_byte_if;
  logic          valid;
  logic          ready;
  qsh_pkg::byte_t data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface qsh_sym_if;
  logic             valid;
  logic             ready;
  qsh_pkg::sample_t i_value;
  qsh_pkg::sample_t q_value;
  logic             byte_last;
  logic             symbol_end;

  modport source (output valid, output i_value, output q_value, output byte_last,
                  output symbol_end, input ready);
  modport sink   (input valid, input i_value, input q_value, input byte_last,
                  input symbol_end, output ready);
endinterface

interface qsh_cfg_if;
  logic          valid;
  logic          ready;
  qsh_pkg::len_t half_bytes;

  modport source (output valid, output half_bytes, input ready);
  modport sink   (input valid, input half_bytes, output ready);
endinterface

[src/qsh_ram.sv]
// generic single-port ram with registered read
// no dependencies

module qsh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

[src/qpsk_split_half_mapper.sv]
// top level of the split-half qpsk mapper: in-phase byte store and symbol serializer
// depends on qsh_pkg, qsh_if (interfaces) and qsh_ram

// A vector is 2*L bytes on bits, L = half_bytes clamped to 1..256. The first L bytes
// (in-phase) are written to a 256x8 ram at one byte per cycle and give no output. Each
// of the last L bytes is paired with the ram entry at the same position and gives 8
// symbols on symbols, most significant bit first, one per cycle while symbols.ready is
// high; a set bit gives -23170, a clear bit +23170. byte_last marks the 8th symbol of
// a byte and symbol_end the last symbol of the vector. A quadrature byte occupies the
// output serializer until its last symbol is taken; one further byte waits in a holding
// stage while the ram read completes. Writing half_bytes restarts the vector.

module qpsk_split_half_mapper (
  input  logic       clk,
  input  logic       rst,
  qsh_byte_if.sink   bits,
  qsh_sym_if.source  symbols,
  qsh_cfg_if.sink    cfg
);

  import qsh_pkg::*;

  len_t                  half_bytes;
  addr_t                 pos;
  logic                  second_half;
  len_t                  len;
  logic                  last_byte;
  logic                  bits_fire;
  logic                  out_fire;
  logic                  load;
  logic                  ram_we;
  logic                  ram_re;
  byte_t                 ram_rdata;

  logic                  s1_valid;
  byte_t                 s1_q;
  logic                  s1_last;

  logic                  active;
  byte_t                 ibits;
  byte_t                 qbits;
  logic [BIT_CNT_W-1:0]  cnt;
  logic                  vec_last;

  always_comb begin
    len = half_bytes;
    if (half_bytes < LEN_MIN) begin
      len = LEN_MIN;
    end else if (half_bytes > LEN_MAX) begin
      len = LEN_MAX;
    end
  end

  assign last_byte = ({1'b0, pos} + LEN_W'(1)) >= len;
  assign out_fire  = symbols.valid && symbols.ready;
  assign load      = s1_valid && (!active || (out_fire && cnt == LAST_BIT));
  assign bits.ready = !second_half || !s1_valid || load;
  assign bits_fire = bits.valid && bits.ready;
  assign ram_we    = bits_fire && !second_half;
  assign ram_re    = bits_fire && second_half;
  assign cfg.ready = 1'b1;

  qsh_ram #(
    .WIDTH (8),
    .DEPTH (MAX_HALF_BYTES)
  ) u_istore (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (pos),
    .wdata (bits.data_byte),
    .rdata (ram_rdata)
  );

  // vector position
  always_ff @(posedge clk) begin
    if (rst) begin
      half_bytes  <= HALF_BYTES_RESET;
      pos         <= '0;
      second_half <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      half_bytes  <= cfg.half_bytes;
      pos         <= '0;
      second_half <= 1'b0;
    end else if (bits_fire) begin
      if (last_byte) begin
        pos         <= '0;
        second_half <= !second_half;
      end else begin
        pos <= pos + ADDR_W'(1);
      end
    end
  end

  // holding stage while the ram read completes
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (ram_re) begin
      s1_valid <= 1'b1;
    end else if (load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      s1_q    <= bits.data_byte;
      s1_last <= last_byte;
    end
  end

  // output serializer
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cnt    <= '0;
    end else if (load) begin
      active <= 1'b1;
      cnt    <= '0;
    end else if (out_fire) begin
      if (cnt == LAST_BIT) begin
        active <= 1'b0;
      end
      cnt <= cnt + BIT_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ibits    <= ram_rdata;
      qbits    <= s1_q;
      vec_last <= s1_last;
    end else if (out_fire) begin
      ibits <= {ibits[6:0], 1'b0};
      qbits <= {qbits[6:0], 1'b0};
    end
  end

  assign symbols.valid      = active;
  assign symbols.i_value    = map_bit(ibits[7]);
  assign symbols.q_value    = map_bit(qbits[7]);
  assign symbols.byte_last  = cnt == LAST_BIT;
  assign symbols.symbol_end = (cnt == LAST_BIT) && vec_last;

  a_end_is_byte_last: assert property (@(posedge clk) disable iff (rst)
    symbols.valid && symbols.symbol_end |-> symbols.byte_last)
    else $error("symbol_end without byte_last");

  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, pos} < len)
    else $error("byte position beyond active length");

  a_no_drop_mid_byte: assert property (@(posedge clk) disable iff (rst)
    out_fire && cnt != LAST_BIT |=> active)
    else $error("serializer stopped inside a byte");

  a_read_held: assert property (@(posedge clk) disable iff (rst)
    ram_re |=> s1_valid)
    else $error("quadrature byte lost after ram read");

endmodule

[dv/tb_top.sv]
// testbench for the split-half qpsk mapper: byte, symbol and config channels, with random gaps
// keeps its own model of the in-phase store and checks every symbol beat in order
// depends on qsh_pkg, qsh_if and the qpsk_split_half_mapper rtl
`timescale 1ns / 100ps

module tb_top;

  import qsh_pkg::*;

  localparam int      STORE_DEPTH = 256;
  localparam sample_t SYM_POS     = 16'sd23170;
  localparam sample_t SYM_NEG     = -16'sd23170;
  localparam int      SETTLE      = 16;
  localparam int      HOLD_CYCLES = 400;
  localparam int      TAIL_CYCLES = 50;
  localparam int      CYCLE_LIMIT = 600000;
  localparam int      RAND_BYTES  = 230;

  typedef enum logic [1:0] {ACT_BYTE, ACT_CFG, ACT_DRAIN, ACT_HOLD} act_e;

  typedef struct {
    act_e  act;
    byte_t data;
    len_t  len;
    bit    quiet;
  } job_t;

  typedef struct {
    sample_t i_value;
    sample_t q_value;
    bit      byte_last;
    bit      symbol_end;
  } symbol_t;

  logic clk;
  logic rst;

  qsh_byte_if byte_bus();
  qsh_sym_if  sym_bus();
  qsh_cfg_if  cfg_bus();

  qpsk_split_half_mapper dut (
    .clk     (clk),
    .rst     (rst),
    .bits    (byte_bus),
    .symbols (sym_bus),
    .cfg     (cfg_bus)
  );

  job_t    jobs[$];
  symbol_t due_symbols[$];

  // model state
  len_t  half_reg;
  byte_t istore[STORE_DEPTH];
  int    vec_pos;
  bit    in_second;

  int    errors;
  int    cycles;
  bit    byte_acc, cfg_acc, sym_acc;
  bit    busy, hold_req, rx_quiet;
  int    tx_gap, rx_wait, hold_left, idle_cnt;
  job_t  cur;

  always #10 clk = ~clk;

  function automatic int eff_len(input len_t hb);
    if (hb == 0) return 1;
    if (hb > STORE_DEPTH) return STORE_DEPTH;
    return int'(hb);
  endfunction

  task automatic map_beat(input byte_t b);
    int      len;
    int      p;
    byte_t   ib;
    symbol_t s;
    len = eff_len(half_reg);
    p = vec_pos;
    if (p >= len) p = 0;
    if (!in_second) begin
      istore[p] = b;
      if (p + 1 >= len) begin
        vec_pos = 0;
        in_second = 1'b1;
      end else begin
        vec_pos = p + 1;
      end
    end else begin
      ib = istore[p];
      for (int k = 0; k < 8; k++) begin
        s.i_value    = ib[7-k] ? SYM_NEG : SYM_POS;
        s.q_value    = b[7-k] ? SYM_NEG : SYM_POS;
        s.byte_last  = (k == 7);
        s.symbol_end = (k == 7) && (p + 1 >= len);
        due_symbols.push_back(s);
      end
      if (p + 1 >= len) begin
        vec_pos = 0;
        in_second = 1'b0;
      end else begin
        vec_pos = p + 1;
      end
    end
  endtask

  // predictor and checker, sampled at the rising edge
  always @(posedge clk) begin
    symbol_t e;
    if (!rst) begin
      if (byte_bus.valid && byte_bus.ready) begin
        byte_acc = 1'b1;
        map_beat(byte_bus.data_byte);
      end
      if (cfg_bus.valid && cfg_bus.ready) begin
        cfg_acc = 1'b1;
        half_reg = cfg_bus.half_bytes;
        vec_pos = 0;
        in_second = 1'b0;
      end
      if (sym_bus.valid && sym_bus.ready) begin
        sym_acc = 1'b1;
        if (due_symbols.size() == 0) begin
          errors++;
          $error("unexpected symbol beat: i_value %0d q_value %0d", sym_bus.i_value,
                 sym_bus.q_value);
        end else begin
          e = due_symbols.pop_front();
          if (sym_bus.i_value !== e.i_value) begin
            errors++;
            $error("i_value mismatch: expected %0d, actual %0d", e.i_value, sym_bus.i_value);
          end
          if (sym_bus.q_value !== e.q_value) begin
            errors++;
            $error("q_value mismatch: expected %0d, actual %0d", e.q_value, sym_bus.q_value);
          end
          if (sym_bus.byte_last !== e.byte_last) begin
            errors++;
            $error("byte_last mismatch: expected %0d, actual %0d", e.byte_last,
                   sym_bus.byte_last);
          end
          if (sym_bus.symbol_end !== e.symbol_end) begin
            errors++;
            $error("symbol_end mismatch: expected %0d, actual %0d", e.symbol_end,
                   sym_bus.symbol_end);
          end
        end
      end
    end
  end

  // byte and config driver
  always @(negedge clk) begin
    if (!rst) begin
      if (busy && (byte_acc || cfg_acc)) begin
        busy = 1'b0;
        tx_gap = cur.quiet ? 0 : $urandom_range(0, 9);
      end
      byte_acc = 1'b0;
      cfg_acc = 1'b0;
      if (due_symbols.size() == 0 && !busy) idle_cnt++;
      else idle_cnt = 0;
      if (!busy) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (jobs.size() > 0) begin
          case (jobs[0].act)
            ACT_BYTE, ACT_CFG: begin
              cur = jobs.pop_front();
              busy = 1'b1;
              rx_quiet = cur.quiet;
            end
            ACT_DRAIN: begin
              if (idle_cnt >= SETTLE) jobs.delete(0);
            end
            ACT_HOLD: begin
              hold_req = 1'b1;
              jobs.delete(0);
            end
            default: begin
              jobs.delete(0);
            end
          endcase
        end
      end
      byte_bus.valid     <= busy && (cur.act == ACT_BYTE);
      byte_bus.data_byte <= cur.data;
      cfg_bus.valid      <= busy && (cur.act == ACT_CFG);
      cfg_bus.half_bytes <= cur.len;
    end
  end

  // symbol receiver
  always @(negedge clk) begin
    if (!rst) begin
      if (sym_acc) begin
        sym_acc = 1'b0;
        rx_wait = rx_quiet ? 0 : $urandom_range(0, 9);
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        sym_bus.ready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        sym_bus.ready <= 1'b0;
      end else begin
        sym_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic push_byte(input byte_t b, input bit q);
    job_t j;
    j.act = ACT_BYTE;
    j.data = b;
    j.len = '0;
    j.quiet = q;
    jobs.push_back(j);
  endtask

  task automatic push_bytes(input int n, input bit q);
    repeat (n) push_byte(byte_t'($urandom_range(0, 255)), q);
  endtask

  task automatic push_mark(input act_e a, input bit q);
    job_t j;
    j.act = a;
    j.data = '0;
    j.len = '0;
    j.quiet = q;
    jobs.push_back(j);
  endtask

  // config writes only once the block has gone idle
  task automatic push_cfg(input len_t hb, input bit q);
    job_t j;
    push_mark(ACT_DRAIN, q);
    j.act = ACT_CFG;
    j.data = '0;
    j.len = hb;
    j.quiet = q;
    jobs.push_back(j);
  endtask

  initial begin
    int   rand_cnt;
    int   len;
    int   nvec;
    int   r;
    len_t hb;
    bit   q;

    clk = 1'b0;
    rst = 1'b1;
    byte_bus.valid = 1'b0;
    byte_bus.data_byte = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.half_bytes = '0;
    sym_bus.ready = 1'b0;
    half_reg = HALF_BYTES_RESET;
    vec_pos = 0;
    in_second = 1'b0;
    errors = 0;
    cycles = 0;
    busy = 1'b0;
    tx_gap = 0;
    rx_wait = 0;
    hold_left = 0;
    idle_cnt = 0;
    rx_quiet = 1'b0;
    cur.act = ACT_BYTE;
    cur.data = '0;
    cur.len = '0;
    cur.quiet = 1'b0;

    // first-half bytes at the reset length, then a restart
    push_bytes(3, 1'b0);
    // one byte per half
    push_cfg(len_t'(1), 1'b0);
    push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0);
    push_byte(8'hff, 1'b0); push_byte(8'hff, 1'b0);
    push_byte(8'haa, 1'b0); push_byte(8'h55, 1'b0);
    push_byte(8'h80, 1'b1); push_byte(8'h01, 1'b1);
    // zero length acts as one
    push_cfg(len_t'(0), 1'b1);
    push_byte(8'h0f, 1'b1); push_byte(8'hf0, 1'b1);
    // restart in the middle of the second half
    push_cfg(len_t'(3), 1'b0);
    push_bytes(4, 1'b0);
    push_cfg(len_t'(2), 1'b0);
    push_bytes(4, 1'b0);
    // largest length, partial fill then restart
    push_cfg(len_t'(256), 1'b0);
    push_bytes(5, 1'b0);

    // long receiver stall while the sender keeps offering beats
    push_cfg(len_t'(4), 1'b1);
    push_mark(ACT_HOLD, 1'b1);
    push_bytes(24, 1'b1);
    rand_cnt = 50;

    // above the maximum, partial fill then restart
    push_cfg(len_t'(511), 1'b0);
    push_bytes(6, 1'b0);
    rand_cnt += 6;

    while (rand_cnt < RAND_BYTES) begin
      r = $urandom_range(0, 9);
      if (r == 0) hb = len_t'(0);
      else if (r < 7) hb = len_t'($urandom_range(1, 6));
      else hb = len_t'($urandom_range(7, 24));
      q = ($urandom_range(0, 3) == 0);
      push_cfg(hb, q);
      len = eff_len(hb);
      nvec = $urandom_range(1, 3);
      repeat (nvec) begin
        push_bytes(2 * len, q);
        rand_cnt += 2 * len;
        if ($urandom_range(0, 3) == 0) push_mark(ACT_DRAIN, q);
      end
      // up to one more vector; a partial one is cut short by the next config write
      if ($urandom_range(0, 4) == 0) begin
        r = $urandom_range(1, 2 * len);
        push_bytes(r, q);
        rand_cnt += r;
      end
    end

    wait (rst == 1'b1);
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    wait (jobs.size() == 0 && !busy);
    wait (due_symbols.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && due_symbols.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
